@@ rtl/rlms_pkg.sv @@
package rlms_pkg;

  // Matrix geometry defaults
  localparam int ROWS_DEF    = 12;
  localparam int COLUMNS_DEF = 16;
  localparam int PLANES      = 3;

  // Bits shifted per row, and per chain
  localparam int SHIFT_BITS = 16;
  localparam int CHAIN_BITS = 8;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 4;
  localparam int COL_END_W = 5;
  localparam int COLOR_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WAIT_W    = 16;
  localparam int CLK_HI_W  = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SPAN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_GAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HIGH  = 3'd4;

  // Configuration reset values
  localparam logic [WAIT_W-1:0]   DWELL_RED_RST   = 16'd90;
  localparam logic [WAIT_W-1:0]   DWELL_GREEN_RST = 16'd200;
  localparam logic [WAIT_W-1:0]   DWELL_BLUE_RST  = 16'd180;
  localparam logic [WAIT_W-1:0]   PLANE_GAP_RST   = 16'd500;
  localparam logic [CLK_HI_W-1:0] CLOCK_HIGH_RST  = 8'd1;

  typedef struct packed {
    logic [WAIT_W-1:0]   dwell_red;
    logic [WAIT_W-1:0]   dwell_green;
    logic [WAIT_W-1:0]   dwell_blue;
    logic [WAIT_W-1:0]   plane_gap;
    logic [CLK_HI_W-1:0] clock_high;
  } cfg_t;

  typedef struct packed {
    logic             data_low;
    logic             data_high;
    logic             shift_clock;
    logic             latch;
    logic             blank;
    logic [ROW_W-1:0] row_select;
    logic             red_on;
    logic             green_on;
    logic             blue_on;
  } pin_t;

endpackage

@@ rtl/rlms_chan_if.sv @@
interface rlms_in_if;
  logic                           valid;
  logic                           ready;
  logic [rlms_pkg::CMD_W-1:0]     cmd;
  logic [rlms_pkg::ROW_W-1:0]     row;
  logic [rlms_pkg::COL_W-1:0]     column_start;
  logic [rlms_pkg::COL_END_W-1:0] column_end;
  logic [rlms_pkg::COLOR_W-1:0]   color;

  modport source (output valid, cmd, row, column_start, column_end, color, input ready);
  modport sink   (input valid, cmd, row, column_start, column_end, color, output ready);
endinterface

interface rlms_out_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic                       serial_data_low;
  logic                       serial_data_high;
  logic                       shift_clock;
  logic                       latch;
  logic                       blank;
  logic [rlms_pkg::ROW_W-1:0] row_select;
  logic                       red_on;
  logic                       green_on;
  logic                       blue_on;

  modport source (output valid, status, serial_data_low, serial_data_high, shift_clock,
                  latch, blank, row_select, red_on, green_on, blue_on, input ready);
  modport sink   (input valid, status, serial_data_low, serial_data_high, shift_clock,
                  latch, blank, row_select, red_on, green_on, blue_on, output ready);
endinterface

@@ rtl/rlms_ram.sv @@
module rlms_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 12
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rlms_store.sv @@
module rlms_store #(
  parameter int ROWS    = rlms_pkg::ROWS_DEF,
  parameter int COLUMNS = rlms_pkg::COLUMNS_DEF
) (
  input  logic [rlms_pkg::CMD_W-1:0]     cmd,
  input  logic [rlms_pkg::ROW_W-1:0]     row,
  input  logic [rlms_pkg::COL_W-1:0]     column_start,
  input  logic [rlms_pkg::COL_END_W-1:0] column_end,
  input  logic [rlms_pkg::COLOR_W-1:0]   color,
  input  logic [rlms_pkg::PLANES*COLUMNS-1:0] old_word,
  output logic                           err,
  output logic [rlms_pkg::PLANES*COLUMNS-1:0] new_word
);

  localparam int CW = 7;

  logic [rlms_pkg::COL_END_W-1:0] end_col;
  logic [CW-1:0]                  start_w;
  logic [CW-1:0]                  end_w;
  logic [COLUMNS-1:0]             mask;
  logic                           row_bad;
  logic                           start_bad;
  logic                           span_bad;

  // Pixel write covers exactly one column
  assign end_col = (cmd == rlms_pkg::CMD_PIXEL) ?
                   rlms_pkg::COL_END_W'({1'b0, column_start} + 5'd1) : column_end;
  assign start_w = CW'(column_start);
  assign end_w   = CW'(end_col);

  assign row_bad   = {1'b0, row} >= 5'(ROWS);
  assign start_bad = start_w >= CW'(COLUMNS);
  assign span_bad  = (end_w > CW'(COLUMNS)) || (end_w <= start_w);

  always_comb begin
    err = 1'b0;
    case (cmd)
      rlms_pkg::CMD_PIXEL: err = row_bad || start_bad;
      rlms_pkg::CMD_SPAN:  err = row_bad || start_bad || span_bad;
      default:             err = 1'b0;
    endcase
  end

  always_comb begin
    for (int c = 0; c < COLUMNS; c++) begin
      mask[c] = (CW'(c) >= start_w) && (CW'(c) < end_w);
    end
  end

  // Set or drop the masked columns in each plane by its color bit
  always_comb begin
    for (int p = 0; p < rlms_pkg::PLANES; p++) begin
      if (color[p]) begin
        new_word[p*COLUMNS +: COLUMNS] = old_word[p*COLUMNS +: COLUMNS] | mask;
      end else begin
        new_word[p*COLUMNS +: COLUMNS] = old_word[p*COLUMNS +: COLUMNS] & ~mask;
      end
    end
  end

endmodule

@@ rtl/rlms_scan.sv @@
module rlms_scan #(
  parameter int ROWS    = rlms_pkg::ROWS_DEF,
  parameter int COLUMNS = rlms_pkg::COLUMNS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  rlms_pkg::cfg_t                      cfg,
  input  logic [rlms_pkg::PLANES*COLUMNS-1:0] row_word,
  output logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] scan_addr,
  output rlms_pkg::pin_t                      pins
);

  localparam int AW = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int SB = rlms_pkg::SHIFT_BITS;

  localparam logic [1:0] PLANE_RED   = 2'd0;
  localparam logic [1:0] PLANE_GREEN = 2'd1;
  localparam logic [1:0] PLANE_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    PH_LOAD, PH_CLK_HIGH, PH_HOLD, PH_CLK_LOW, PH_LATCH, PH_SHOW, PH_DWELL, PH_GAP
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [1:0]                   plane_r, plane_nxt;
  logic [rlms_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [2:0]                   bit_r, bit_nxt;
  logic [rlms_pkg::WAIT_W-1:0]  wait_r, wait_nxt;
  logic [SB-1:0]                bits_r, bits_nxt;
  rlms_pkg::pin_t               pins_r, pins_nxt;

  logic [1:0]                   plane_sat;
  logic [COLUMNS-1:0]           plane_word;
  logic [COLUMNS+SB-1:0]        plane_pad;
  logic [rlms_pkg::WAIT_W-1:0]  wait_dec;
  logic [rlms_pkg::WAIT_W-1:0]  dwell;
  logic [rlms_pkg::CLK_HI_W-1:0] high_n;
  logic                         end_row;
  logic                         end_plane;

  assign plane_sat  = (plane_r > PLANE_BLUE) ? PLANE_BLUE : plane_r;
  assign plane_word = row_word[plane_sat*COLUMNS +: COLUMNS];
  // Columns that do not exist shift out as zero
  assign plane_pad  = {{SB{1'b0}}, plane_word};
  assign wait_dec   = (wait_r == '0) ? '0 : wait_r - 1'b1;
  assign high_n     = (cfg.clock_high == '0) ? 8'd1 : cfg.clock_high;
  assign scan_addr  = AW'(rlms_pkg::ROW_W'(ROWS - 1) - row_r);
  assign pins       = pins_r;

  always_comb begin
    case (plane_sat)
      PLANE_RED:   dwell = cfg.dwell_red;
      PLANE_GREEN: dwell = cfg.dwell_green;
      default:     dwell = cfg.dwell_blue;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    plane_nxt = plane_r;
    row_nxt   = row_r;
    bit_nxt   = bit_r;
    wait_nxt  = wait_r;
    bits_nxt  = bits_r;
    pins_nxt  = pins_r;
    end_row   = 1'b0;
    end_plane = 1'b0;
    case (phase_r)
      PH_LOAD: begin
        pins_nxt.red_on   = plane_sat == PLANE_RED;
        pins_nxt.green_on = plane_sat == PLANE_GREEN;
        pins_nxt.blue_on  = plane_sat == PLANE_BLUE;
        pins_nxt.latch    = 1'b0;
        bits_nxt  = plane_pad[SB-1:0];
        bit_nxt   = '0;
        phase_nxt = PH_CLK_HIGH;
      end
      PH_CLK_HIGH: begin
        pins_nxt.data_low    = bits_r[{1'b0, bit_r}];
        pins_nxt.data_high   = bits_r[{1'b1, bit_r}];
        pins_nxt.shift_clock = 1'b1;
        if (high_n == 8'd1) begin
          phase_nxt = PH_CLK_LOW;
        end else begin
          wait_nxt  = rlms_pkg::WAIT_W'(high_n - 8'd1);
          phase_nxt = PH_HOLD;
        end
      end
      PH_HOLD: begin
        wait_nxt = wait_dec;
        if (wait_dec == '0) begin
          phase_nxt = PH_CLK_LOW;
        end
      end
      PH_CLK_LOW: begin
        pins_nxt.shift_clock = 1'b0;
        if (bit_r == 3'd7) begin
          bit_nxt   = '0;
          phase_nxt = PH_LATCH;
        end else begin
          bit_nxt   = bit_r + 3'd1;
          phase_nxt = PH_CLK_HIGH;
        end
      end
      PH_LATCH: begin
        pins_nxt.blank      = 1'b1;
        pins_nxt.latch      = 1'b1;
        pins_nxt.row_select = row_r;
        phase_nxt = PH_SHOW;
      end
      PH_SHOW: begin
        pins_nxt.blank = 1'b0;
        if (dwell == '0) begin
          end_row = 1'b1;
        end else begin
          wait_nxt  = dwell;
          phase_nxt = PH_DWELL;
        end
      end
      PH_DWELL: begin
        wait_nxt = wait_dec;
        end_row  = wait_dec == '0;
      end
      default: begin
        wait_nxt  = wait_dec;
        end_plane = wait_dec == '0;
      end
    endcase

    // Advance to the next row, or finish the plane after the last one
    if (end_row) begin
      if ({1'b0, row_r} + 5'd1 >= 5'(ROWS)) begin
        row_nxt = '0;
        if (cfg.plane_gap == '0) begin
          end_plane = 1'b1;
        end else begin
          wait_nxt  = cfg.plane_gap;
          phase_nxt = PH_GAP;
        end
      end else begin
        row_nxt   = row_r + 1'b1;
        phase_nxt = PH_LOAD;
      end
    end
    if (end_plane) begin
      plane_nxt = (plane_r >= PLANE_BLUE) ? PLANE_RED : plane_r + 2'd1;
      phase_nxt = PH_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOAD;
      plane_r <= PLANE_RED;
      row_r   <= '0;
      bit_r   <= '0;
      wait_r  <= '0;
      bits_r  <= '0;
      pins_r  <= '{data_low: 1'b0, data_high: 1'b0, shift_clock: 1'b0, latch: 1'b0,
                   blank: 1'b1, row_select: '0, red_on: 1'b0, green_on: 1'b0,
                   blue_on: 1'b0};
    end else if (step) begin
      phase_r <= phase_nxt;
      plane_r <= plane_nxt;
      row_r   <= row_nxt;
      bit_r   <= bit_nxt;
      wait_r  <= wait_nxt;
      bits_r  <= bits_nxt;
      pins_r  <= pins_nxt;
    end
  end

endmodule

@@ rtl/rgb_led_matrix_scan.sv @@
// Scan controller for a multiplexed RGB LED matrix of ROWS x COLUMNS pixels. The frame store
// is a one-port-write, one-port-read RAM with one row per entry, holding the red, green and
// blue bits of every column of that row; a valid flag per row (flip-flops) makes rows read as
// off after reset and after a clear, so neither needs a sweep through the RAM. Every transfer
// on the input channel is one command: tick (advance the scan one phase), write pixel, write
// row span, or clear all. Each command produces exactly one result: the status bit and the
// pin levels after the command. The transfer cycle reads the addressed row from the RAM (the
// row the scan loads next for a tick, the target row for a write); the execute state then
// merges, writes back and steps the scan: a read-modify-write of that row through the RAM.
// The result sits in an output register, so the next command is taken while it waits; a new
// result is held back only while that register is still full. Configuration writes on the
// cfg_ port are taken any time the block is idle; indexes beyond the register list are dropped.
module rgb_led_matrix_scan #(
  parameter int ROWS    = rlms_pkg::ROWS_DEF,
  parameter int COLUMNS = rlms_pkg::COLUMNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rlms_in_if.sink                           in_ch,
  rlms_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [rlms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int WW = rlms_pkg::PLANES * COLUMNS;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t                         state_r, state_nxt;
  logic [rlms_pkg::CMD_W-1:0]     cmd_r;
  logic [rlms_pkg::ROW_W-1:0]     row_r;
  logic [rlms_pkg::COL_W-1:0]     col_start_r;
  logic [rlms_pkg::COL_END_W-1:0] col_end_r;
  logic [rlms_pkg::COLOR_W-1:0]   color_r;
  logic [AW-1:0]                  addr_r;
  logic [ROWS-1:0]                row_valid_r;
  logic                           out_valid_r;
  logic                           status_r;
  rlms_pkg::cfg_t                 cfg_r;

  logic                           in_xfer;
  logic                           exec_go;
  logic                           is_write;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  ram_raddr;
  logic [AW-1:0]                  scan_addr;
  logic [WW-1:0]                  ram_rdata;
  logic [WW-1:0]                  old_word;
  logic [WW-1:0]                  new_word;
  logic                           err;
  logic                           ram_we;
  rlms_pkg::pin_t                 pins;

  // Take a command only between executions; the read is issued in the transfer cycle
  assign in_ch.ready = state_r == ST_IDLE;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Execute once the output register is free or being emptied in this cycle
  assign exec_go  = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign is_write = (cmd_r == rlms_pkg::CMD_PIXEL) || (cmd_r == rlms_pkg::CMD_SPAN);
  assign ram_we   = exec_go && is_write && !err;

  // Out-of-range rows point at entry 0; the write is rejected anyway
  always_comb begin
    if (in_ch.cmd == rlms_pkg::CMD_TICK) begin
      rd_addr = scan_addr;
    end else if ({1'b0, in_ch.row} < 5'(ROWS)) begin
      rd_addr = in_ch.row[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  // Hold the read on the latched row while an execution waits for the output register
  assign ram_raddr = (state_r == ST_IDLE) ? rd_addr : addr_r;

  // Rows never written since reset or the last clear read as all off
  assign old_word = row_valid_r[addr_r] ? ram_rdata : '0;

  rlms_ram #(
    .WIDTH (WW),
    .DEPTH (ROWS)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (new_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rlms_store #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_store (
    .cmd          (cmd_r),
    .row          (row_r),
    .column_start (col_start_r),
    .column_end   (col_end_r),
    .color        (color_r),
    .old_word     (old_word),
    .err          (err),
    .new_word     (new_word)
  );

  rlms_scan #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (exec_go && (cmd_r == rlms_pkg::CMD_TICK)),
    .cfg       (cfg_r),
    .row_word  (old_word),
    .scan_addr (scan_addr),
    .pins      (pins)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_EXEC;
      ST_EXEC: if (exec_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, store valid flags and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
      status_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        out_valid_r <= 1'b1;
        status_r    <= err;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (exec_go && (cmd_r == rlms_pkg::CMD_CLEAR)) begin
        row_valid_r <= '0;
      end else if (ram_we) begin
        row_valid_r[addr_r] <= 1'b1;
      end
    end
  end

  // Hold the command fields and read address for the execute cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r       <= in_ch.cmd;
      row_r       <= in_ch.row;
      col_start_r <= in_ch.column_start;
      col_end_r   <= in_ch.column_end;
      color_r     <= in_ch.color;
      addr_r      <= rd_addr;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dwell_red   <= rlms_pkg::DWELL_RED_RST;
      cfg_r.dwell_green <= rlms_pkg::DWELL_GREEN_RST;
      cfg_r.dwell_blue  <= rlms_pkg::DWELL_BLUE_RST;
      cfg_r.plane_gap   <= rlms_pkg::PLANE_GAP_RST;
      cfg_r.clock_high  <= rlms_pkg::CLOCK_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rlms_pkg::CFG_DWELL_RED:   cfg_r.dwell_red   <= cfg_data;
        rlms_pkg::CFG_DWELL_GREEN: cfg_r.dwell_green <= cfg_data;
        rlms_pkg::CFG_DWELL_BLUE:  cfg_r.dwell_blue  <= cfg_data;
        rlms_pkg::CFG_PLANE_GAP:   cfg_r.plane_gap   <= cfg_data;
        rlms_pkg::CFG_CLOCK_HIGH:  cfg_r.clock_high  <= cfg_data[rlms_pkg::CLK_HI_W-1:0];
        default: ;
      endcase
    end
  end

  // Pins change only when a result is loaded, so they stand as part of the output register
  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.serial_data_low  = pins.data_low;
  assign out_ch.serial_data_high = pins.data_high;
  assign out_ch.shift_clock      = pins.shift_clock;
  assign out_ch.latch            = pins.latch;
  assign out_ch.blank            = pins.blank;
  assign out_ch.row_select       = pins.row_select;
  assign out_ch.red_on           = pins.red_on;
  assign out_ch.green_on         = pins.green_on;
  assign out_ch.blue_on          = pins.blue_on;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import rlms_pkg::*;

  localparam int ROWS        = ROWS_DEF;
  localparam int IDLE_PCT    = 29;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_TICKS = 12;

  // Phases of the scan engine, one per tick
  typedef enum logic [2:0] {
    SCAN_LOAD, SCAN_CLK_HIGH, SCAN_HOLD, SCAN_CLK_LOW,
    SCAN_LATCH, SCAN_SHOW, SCAN_DWELL, SCAN_GAP
  } scan_phase_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col_start;
    logic [COL_END_W-1:0] col_end;
    logic [COLOR_W-1:0]   color;
  } matrix_cmd_t;

  typedef struct packed {
    logic status;
    pin_t pins;
  } pin_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rlms_in_if  in_ch ();
  rlms_out_if out_ch ();

  rgb_led_matrix_scan uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Commands waiting to go out, and pin reports still owed by the block
  matrix_cmd_t cmd_queue[$];
  pin_report_t report_queue[$];
  matrix_cmd_t cmd_on_bus;

  logic no_idle;
  int   fail_count;
  int   stall_cycles;

  // Shadow copy of the block: frame store, scan engine, pins, registers
  logic [SHIFT_BITS-1:0] frame_model [PLANES][ROWS];
  int unsigned           plane_idx;
  int unsigned           row_idx;
  int unsigned           bit_idx;
  int unsigned           wait_cnt;
  scan_phase_t           scan_ph;
  logic [SHIFT_BITS-1:0] shift_word;
  pin_t                  pin_model;
  cfg_t                  cfg_model;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wrap up one plane: step to the next color, back to red after blue
  function automatic void close_plane();
    plane_idx = (plane_idx >= 2) ? 0 : plane_idx + 1;
    scan_ph   = SCAN_LOAD;
  endfunction

  // Wrap up one row: next row, or the plane gap after the last one
  function automatic void close_row();
    if (row_idx + 1 >= ROWS) begin
      row_idx = 0;
      if (cfg_model.plane_gap == 0) begin
        close_plane();
      end else begin
        wait_cnt = 32'(cfg_model.plane_gap);
        scan_ph  = SCAN_GAP;
      end
    end else begin
      row_idx++;
      scan_ph = SCAN_LOAD;
    end
  endfunction

  // Advance the scan engine by one tick
  function automatic void step_scan();
    int unsigned p;
    int unsigned hold;
    int unsigned dwell;
    p = (plane_idx > 2) ? 2 : plane_idx;
    case (scan_ph)
      SCAN_LOAD: begin
        pin_model.red_on   = (p == 0);
        pin_model.green_on = (p == 1);
        pin_model.blue_on  = (p == 2);
        pin_model.latch    = 1'b0;
        // Scan row i shows store row ROWS-1-i
        shift_word = frame_model[p][ROWS - 1 - row_idx];
        bit_idx    = 0;
        scan_ph    = SCAN_CLK_HIGH;
      end
      SCAN_CLK_HIGH: begin
        pin_model.data_low    = shift_word[bit_idx];
        pin_model.data_high   = shift_word[CHAIN_BITS + bit_idx];
        pin_model.shift_clock = 1'b1;
        // A zero high time counts as one tick
        hold = (cfg_model.clock_high == 0) ? 1 : 32'(cfg_model.clock_high);
        if (hold == 1) begin
          scan_ph = SCAN_CLK_LOW;
        end else begin
          wait_cnt = hold - 1;
          scan_ph  = SCAN_HOLD;
        end
      end
      SCAN_HOLD: begin
        if (wait_cnt > 0) wait_cnt--;
        if (wait_cnt == 0) scan_ph = SCAN_CLK_LOW;
      end
      SCAN_CLK_LOW: begin
        pin_model.shift_clock = 1'b0;
        if (bit_idx >= CHAIN_BITS - 1) begin
          bit_idx = 0;
          scan_ph = SCAN_LATCH;
        end else begin
          bit_idx++;
          scan_ph = SCAN_CLK_HIGH;
        end
      end
      SCAN_LATCH: begin
        pin_model.blank      = 1'b1;
        pin_model.latch      = 1'b1;
        pin_model.row_select = row_idx[ROW_W-1:0];
        scan_ph              = SCAN_SHOW;
      end
      SCAN_SHOW: begin
        pin_model.blank = 1'b0;
        dwell = (p == 0) ? 32'(cfg_model.dwell_red) :
                (p == 1) ? 32'(cfg_model.dwell_green) : 32'(cfg_model.dwell_blue);
        // A zero dwell ends the row in this same tick
        if (dwell == 0) begin
          close_row();
        end else begin
          wait_cnt = dwell;
          scan_ph  = SCAN_DWELL;
        end
      end
      SCAN_DWELL: begin
        if (wait_cnt > 0) wait_cnt--;
        if (wait_cnt == 0) close_row();
      end
      default: begin
        if (wait_cnt > 0) wait_cnt--;
        if (wait_cnt == 0) close_plane();
      end
    endcase
  endfunction

  // Apply one command to the shadow copy and return the pins it leaves
  function automatic pin_report_t apply_command(matrix_cmd_t c);
    pin_report_t           rep;
    logic [SHIFT_BITS-1:0] mask;
    logic                  bad;
    mask = '0;
    bad  = 1'b0;
    case (c.cmd)
      CMD_TICK: step_scan();
      CMD_PIXEL: begin
        bad = (c.row >= ROWS) || (c.col_start >= COLUMNS_DEF);
        if (!bad) mask[c.col_start] = 1'b1;
      end
      CMD_SPAN: begin
        // Reject out of range rows and columns, and empty or reversed spans
        bad = (c.row >= ROWS) || (c.col_start >= COLUMNS_DEF) ||
              (c.col_end > COLUMNS_DEF) || (c.col_end <= c.col_start);
        if (!bad) begin
          for (int col = int'(c.col_start); col < c.col_end; col++) mask[col] = 1'b1;
        end
      end
      default: begin
        for (int p = 0; p < PLANES; p++) begin
          for (int r = 0; r < ROWS; r++) frame_model[p][r] = '0;
        end
      end
    endcase
    if ((c.cmd == CMD_PIXEL || c.cmd == CMD_SPAN) && !bad) begin
      for (int p = 0; p < PLANES; p++) begin
        if (c.color[p]) frame_model[p][c.row] = frame_model[p][c.row] | mask;
        else            frame_model[p][c.row] = frame_model[p][c.row] & ~mask;
      end
    end
    rep.status = bad;
    rep.pins   = pin_model;
    return rep;
  endfunction

  function automatic matrix_cmd_t make_cmd(logic [CMD_W-1:0] cmd, int row, int cs, int ce,
                                           int color);
    matrix_cmd_t c;
    c.cmd       = cmd;
    c.row       = row[ROW_W-1:0];
    c.col_start = cs[COL_W-1:0];
    c.col_end   = ce[COL_END_W-1:0];
    c.color     = color[COLOR_W-1:0];
    return c;
  endfunction

  // Mostly ticks with a steady trickle of well-formed writes; some writes are
  // pushed out of range, and a rare clear wipes the picture
  function automatic matrix_cmd_t random_cmd();
    matrix_cmd_t c;
    int unsigned pick;
    int unsigned cs;
    pick = $urandom_range(0, 99);
    cs   = $urandom_range(0, 15);
    c = make_cmd(CMD_TICK, $urandom_range(0, 11), cs, $urandom_range(cs + 1, 16),
                 $urandom_range(0, 7));
    if (pick < 70) begin
      c.cmd       = CMD_TICK;
      c.row       = ROW_W'($urandom_range(0, 15));
      c.col_end   = COL_END_W'($urandom_range(0, 16));
    end else if (pick < 83) begin
      c.cmd = CMD_PIXEL;
    end else if (pick < 97) begin
      c.cmd = CMD_SPAN;
    end else begin
      c.cmd = CMD_CLEAR;
    end
    if (c.cmd != CMD_TICK && $urandom_range(0, 9) == 0) begin
      c.row     = ROW_W'($urandom_range(0, 15));
      c.col_end = COL_END_W'($urandom_range(0, 16));
    end
    return c;
  endfunction

  // Write one register, and keep the shadow copy in step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_DWELL_RED:   cfg_model.dwell_red   = value;
      CFG_DWELL_GREEN: cfg_model.dwell_green = value;
      CFG_DWELL_BLUE:  cfg_model.dwell_blue  = value;
      CFG_PLANE_GAP:   cfg_model.plane_gap   = value;
      CFG_CLOCK_HIGH:  cfg_model.clock_high  = value[CLK_HI_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all_regs(int red, int green, int blue, int gap, int clk_high);
    write_reg(CFG_DWELL_RED,   red[CFG_DATA_W-1:0]);
    write_reg(CFG_DWELL_GREEN, green[CFG_DATA_W-1:0]);
    write_reg(CFG_DWELL_BLUE,  blue[CFG_DATA_W-1:0]);
    write_reg(CFG_PLANE_GAP,   gap[CFG_DATA_W-1:0]);
    write_reg(CFG_CLOCK_HIGH,  clk_high[CFG_DATA_W-1:0]);
  endtask

  // Hold until every command is out and every report is back, then let the
  // block settle before returning
  task automatic wait_drained();
    do @(posedge clk);
    while (cmd_queue.size() != 0 || in_ch.valid || report_queue.size() != 0);
    repeat (DRAIN_TICKS) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    repeat (count) cmd_queue.push_back(random_cmd());
  endtask

  // Driver: record each transfer, then present the next command or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        report_queue.push_back(apply_command(cmd_on_bus));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cmd_on_bus         = cmd_queue.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.cmd          <= cmd_on_bus.cmd;
          in_ch.row          <= cmd_on_bus.row;
          in_ch.column_start <= cmd_on_bus.col_start;
          in_ch.column_end   <= cmd_on_bus.col_end;
          in_ch.color        <= cmd_on_bus.color;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [ROW_W-1:0] exp, logic [ROW_W-1:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      fail_count++;
    end
  endtask

  // Monitor: compare each report transfer against the oldest prediction
  always @(posedge clk) begin
    pin_report_t exp;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (report_queue.size() == 0) begin
          $error("report with no command waiting for it");
          fail_count++;
        end else begin
          exp = report_queue.pop_front();
          check_field("status", ROW_W'(exp.status), ROW_W'(out_ch.status));
          check_field("serial_data_low", ROW_W'(exp.pins.data_low),
                      ROW_W'(out_ch.serial_data_low));
          check_field("serial_data_high", ROW_W'(exp.pins.data_high),
                      ROW_W'(out_ch.serial_data_high));
          check_field("shift_clock", ROW_W'(exp.pins.shift_clock),
                      ROW_W'(out_ch.shift_clock));
          check_field("latch", ROW_W'(exp.pins.latch), ROW_W'(out_ch.latch));
          check_field("blank", ROW_W'(exp.pins.blank), ROW_W'(out_ch.blank));
          check_field("row_select", exp.pins.row_select, out_ch.row_select);
          check_field("red_on", ROW_W'(exp.pins.red_on), ROW_W'(out_ch.red_on));
          check_field("green_on", ROW_W'(exp.pins.green_on), ROW_W'(out_ch.green_on));
          check_field("blue_on", ROW_W'(exp.pins.blue_on), ROW_W'(out_ch.blue_on));
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: drop the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_TICK;
    in_ch.row          = '0;
    in_ch.column_start = '0;
    in_ch.column_end   = '0;
    in_ch.color        = '0;
    out_ch.ready       = 1'b0;
    no_idle            = 1'b0;
    fail_count         = 0;
    stall_cycles       = 0;

    // Shadow copy starts from the reset state of the block
    for (int p = 0; p < PLANES; p++) begin
      for (int r = 0; r < ROWS; r++) frame_model[p][r] = '0;
    end
    plane_idx  = 0;
    row_idx    = 0;
    bit_idx    = 0;
    wait_cnt   = 0;
    scan_ph    = SCAN_LOAD;
    shift_word = '0;
    pin_model  = '{data_low: 1'b0, data_high: 1'b0, shift_clock: 1'b0, latch: 1'b0,
                   blank: 1'b1, row_select: '0, red_on: 1'b0, green_on: 1'b0,
                   blue_on: 1'b0};
    cfg_model  = '{dwell_red: DWELL_RED_RST, dwell_green: DWELL_GREEN_RST,
                   dwell_blue: DWELL_BLUE_RST, plane_gap: PLANE_GAP_RST,
                   clock_high: CLOCK_HIGH_RST};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corner pixels, bad rows, full, single and empty spans, clear
    cmd_queue.push_back(make_cmd(CMD_TICK,  0,  0,  0, 0));
    cmd_queue.push_back(make_cmd(CMD_PIXEL, 11, 0,  0, 7));
    cmd_queue.push_back(make_cmd(CMD_PIXEL, 0,  15, 0, 7));
    cmd_queue.push_back(make_cmd(CMD_PIXEL, 12, 3,  0, 1));
    cmd_queue.push_back(make_cmd(CMD_PIXEL, 15, 15, 16, 7));
    cmd_queue.push_back(make_cmd(CMD_SPAN,  5,  0,  16, 7));
    cmd_queue.push_back(make_cmd(CMD_SPAN,  3,  4,  4,  7));
    cmd_queue.push_back(make_cmd(CMD_SPAN,  3,  5,  4,  2));
    cmd_queue.push_back(make_cmd(CMD_SPAN,  2,  15, 16, 1));
    cmd_queue.push_back(make_cmd(CMD_SPAN,  4,  0,  1,  2));
    cmd_queue.push_back(make_cmd(CMD_SPAN,  13, 0,  16, 4));
    cmd_queue.push_back(make_cmd(CMD_SPAN,  5,  3,  9,  0));
    cmd_queue.push_back(make_cmd(CMD_CLEAR, 0,  0,  0,  0));
    cmd_queue.push_back(make_cmd(CMD_PIXEL, 11, 8,  0,  5));
    cmd_queue.push_back(make_cmd(CMD_SPAN,  11, 0,  8,  3));
    repeat (10) cmd_queue.push_back(make_cmd(CMD_TICK, 15, 15, 16, 7));
    queue_random(200);
    wait_drained();

    // Zero dwells and gap, zero high time: every wait is skipped
    write_all_regs(0, 0, 0, 0, 0);
    queue_random(300);
    wait_drained();

    // Short waits with no idling on either side
    no_idle = 1'b1;
    write_all_regs($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                   $urandom_range(1, 6), $urandom_range(1, 3));
    queue_random(400);
    wait_drained();
    no_idle = 1'b0;

    // Mixed moderate waits, minimum high time
    write_all_regs($urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20),
                   $urandom_range(0, 30), 1);
    queue_random(300);
    wait_drained();

    // Largest values last, since a long dwell never finishes in this run
    write_all_regs(65535, 65535, 65535, 65535, 255);
    queue_random(300);
    wait_drained();

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
